// ===== rtl/longest_match_tokenizer_defines.svh =====
// Assertion macros shared by the checker of the tokenizer.
`ifndef LONGEST_MATCH_TOKENIZER_DEFINES_SVH
`define LONGEST_MATCH_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LMT_ASSERT_SAME(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LMT_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// ===== rtl/lmt_pkg.sv =====
package lmt_pkg;

  typedef enum logic [4:0] {
    S_IDLE, S_NINT, S_NDOT, S_NFRAC, S_NE, S_NESIGN, S_NEXP,
    S_ID, S_I, S_IF, S_IN, S_INT, S_E, S_EL, S_ELS, S_ELSE
  } scan_state_t;

  typedef enum logic [3:0] {
    K_NUM     = 4'd0,
    K_ID      = 4'd1,
    K_IF      = 4'd2,
    K_ELSE    = 4'd3,
    K_INT     = 4'd4,
    K_LPAREN  = 4'd5,
    K_RPAREN  = 4'd6,
    K_EQUAL   = 4'd7,
    K_LESS    = 4'd8,
    K_GREATER = 4'd9,
    K_INVALID = 4'd10
  } tok_kind_t;

  typedef enum logic [1:0] {OP_ADVANCE, OP_BASIC, OP_FLUSH} step_op_t;

  typedef enum logic [1:0] {SQ_IDLE, SQ_RUN, SQ_RESCAN, SQ_FINISH} seq_state_t;

  typedef struct packed {
    logic      emit;
    logic      retry;
    logic      fail;
    logic [1:0] pend_cnt;
    logic      lb_wr0;
    logic      lb_wr1;
    tok_kind_t kind;
  } step_ctl_t;

  localparam int LB_DEPTH = 2;
  localparam int LB_IDX_W = $clog2(LB_DEPTH);

  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_0      = "0";
  localparam logic [7:0] CH_9      = "9";
  localparam logic [7:0] CH_LO_A   = "a";
  localparam logic [7:0] CH_LO_Z   = "z";
  localparam logic [7:0] CH_UP_A   = "A";
  localparam logic [7:0] CH_UP_Z   = "Z";
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_UP_E   = "E";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_EQUAL  = "=";
  localparam logic [7:0] CH_LESS   = "<";
  localparam logic [7:0] CH_GREATER = ">";
  localparam logic [7:0] CH_LO_I   = "i";
  localparam logic [7:0] CH_LO_F   = "f";
  localparam logic [7:0] CH_LO_N   = "n";
  localparam logic [7:0] CH_LO_T   = "t";
  localparam logic [7:0] CH_LO_E   = "e";
  localparam logic [7:0] CH_LO_L   = "l";
  localparam logic [7:0] CH_LO_S   = "s";

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_num_state(input scan_state_t s);
    return (s >= S_NINT) && (s <= S_NEXP);
  endfunction

  function automatic logic is_id_state(input scan_state_t s);
    return (s >= S_ID) && (s <= S_ELSE);
  endfunction

  function automatic tok_kind_t id_kind(input scan_state_t s);
    tok_kind_t k;
    case (s)
      S_IF:    k = K_IF;
      S_ELSE:  k = K_ELSE;
      S_INT:   k = K_INT;
      default: k = K_ID;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] pending_count(input scan_state_t s);
    logic [1:0] n;
    case (s)
      S_NDOT, S_NE: n = 2'd1;
      S_NESIGN:     n = 2'd2;
      default:      n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/longest_match_tokenizer.sv =====
// Longest-match tokenizer: bytes come in one item at a time and tokens go out one item at a
// time, each with its kind, stream offset and saturated length, the last token caused by an
// input item carrying out_last_of_run. A single scanner step unit handles one byte per cycle,
// except while a token waits for the result side, under a small sequencer. Each input item is
// stepped and finished before the next is accepted, and its byte goes through the step unit again
// when it ends a number, or ends an identifier without being whitespace. When a number is
// abandoned, its pending '.', 'E' or sign bytes go through the step unit again one at a time,
// a byte once more when it ends a token among them; a result side that stalls holds the run.
// in_ready is high only between items.
module longest_match_tokenizer #(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_kind,
  output logic [31:0] out_start_offset,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);

  lmt_pkg::seq_state_t     seq_r, seq_nxt;
  lmt_pkg::step_op_t       op_r;
  logic [7:0]              cur_char_r;
  logic [31:0]             cur_pos_r;
  logic [1:0]              left_r;
  logic [lmt_pkg::LB_IDX_W-1:0] idx_r;

  lmt_pkg::scan_state_t    scan_r;
  logic                    skip_r;
  logic [31:0]             position_r;
  logic [31:0]             tok_start_r;
  logic [LENGTH_WIDTH-1:0] acc_len_r;
  logic [LENGTH_WIDTH-1:0] scan_len_r;
  logic [7:0]              lb_r [lmt_pkg::LB_DEPTH];

  logic                    hold_v_r;
  lmt_pkg::tok_kind_t      hold_kind_r;
  logic [31:0]             hold_start_r;
  logic [15:0]             hold_len_r;

  logic                    out_valid_r;
  lmt_pkg::tok_kind_t      out_kind_r;
  logic [31:0]             out_start_r;
  logic [15:0]             out_len_r;
  logic                    out_last_r;

  lmt_pkg::step_op_t       step_op;
  logic [7:0]              step_char;
  logic [31:0]             step_pos;
  lmt_pkg::scan_state_t    st_scan;
  logic                    st_skip;
  logic [31:0]             st_tok_start;
  logic [LENGTH_WIDTH-1:0] st_acc_len;
  logic [LENGTH_WIDTH-1:0] st_scan_len;
  lmt_pkg::step_ctl_t      st_ctl;
  logic [31:0]             st_emit_start;
  logic [LENGTH_WIDTH-1:0] st_emit_len;

  logic in_acc;
  logic out_slot;
  logic step_go;
  logic finish_go;
  logic push;

  lmt_step #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_step (
    .op_i         (step_op),
    .scan_i       (scan_r),
    .skip_i       (skip_r),
    .char_i       (step_char),
    .pos_i        (step_pos),
    .tok_start_i  (tok_start_r),
    .acc_len_i    (acc_len_r),
    .scan_len_i   (scan_len_r),
    .scan_o       (st_scan),
    .skip_o       (st_skip),
    .tok_start_o  (st_tok_start),
    .acc_len_o    (st_acc_len),
    .scan_len_o   (st_scan_len),
    .ctl_o        (st_ctl),
    .emit_start_o (st_emit_start),
    .emit_len_o   (st_emit_len)
  );

  // Sequencer outputs and the operand selection of the step unit.
  always_comb begin
    in_ready  = (seq_r == lmt_pkg::SQ_IDLE);
    in_acc    = in_valid && in_ready;
    out_slot  = !out_valid_r || out_ready;
    step_op   = op_r;
    step_char = cur_char_r;
    step_pos  = cur_pos_r;
    if (seq_r == lmt_pkg::SQ_RESCAN) begin
      step_op   = lmt_pkg::OP_BASIC;
      step_char = lb_r[idx_r];
      step_pos  = cur_pos_r - 32'(left_r);
    end
    step_go   = ((seq_r == lmt_pkg::SQ_RUN) || (seq_r == lmt_pkg::SQ_RESCAN)) &&
                !(st_ctl.emit && hold_v_r && !out_slot);
    finish_go = (seq_r == lmt_pkg::SQ_FINISH) && (!hold_v_r || out_slot);
    push      = hold_v_r && ((step_go && st_ctl.emit) || finish_go);
  end

  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      lmt_pkg::SQ_IDLE: begin
        if (in_acc) seq_nxt = lmt_pkg::SQ_RUN;
      end
      lmt_pkg::SQ_RUN: begin
        if (step_go) begin
          if (st_ctl.fail && (st_ctl.pend_cnt != 2'd0)) seq_nxt = lmt_pkg::SQ_RESCAN;
          else if (st_ctl.fail || st_ctl.retry) seq_nxt = lmt_pkg::SQ_RUN;
          else seq_nxt = lmt_pkg::SQ_FINISH;
        end
      end
      lmt_pkg::SQ_RESCAN: begin
        if (step_go && !st_ctl.retry && (left_r == 2'd1)) seq_nxt = lmt_pkg::SQ_RUN;
      end
      lmt_pkg::SQ_FINISH: begin
        if (finish_go) seq_nxt = lmt_pkg::SQ_IDLE;
      end
      default: seq_nxt = lmt_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= lmt_pkg::SQ_IDLE;
      scan_r      <= lmt_pkg::S_IDLE;
      skip_r      <= 1'b0;
      position_r  <= '0;
      tok_start_r <= '0;
      acc_len_r   <= '0;
      scan_len_r  <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r <= seq_nxt;
      if (in_acc && !in_end_of_text) position_r <= position_r + 32'd1;
      if (step_go) begin
        scan_r      <= st_scan;
        skip_r      <= st_skip;
        tok_start_r <= st_tok_start;
        acc_len_r   <= st_acc_len;
        scan_len_r  <= st_scan_len;
        if (st_ctl.emit) hold_v_r <= 1'b1;
      end else if (finish_go) begin
        hold_v_r <= 1'b0;
      end
      if (push) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_char_r <= in_char_code;
      cur_pos_r  <= position_r;
      op_r       <= (in_end_of_text || lmt_pkg::is_space(in_char_code)) ?
                    lmt_pkg::OP_FLUSH : lmt_pkg::OP_ADVANCE;
    end
    if (step_go && (seq_r == lmt_pkg::SQ_RUN) && st_ctl.fail) begin
      left_r <= st_ctl.pend_cnt;
      idx_r  <= '0;
    end else if (step_go && (seq_r == lmt_pkg::SQ_RESCAN) && !st_ctl.retry) begin
      left_r <= left_r - 2'd1;
      idx_r  <= idx_r + 1'b1;
    end
    if (step_go && st_ctl.lb_wr0) lb_r[0] <= step_char;
    if (step_go && st_ctl.lb_wr1) lb_r[1] <= step_char;
    if (step_go && st_ctl.emit) begin
      hold_kind_r  <= st_ctl.kind;
      hold_start_r <= st_emit_start;
      hold_len_r   <= 16'(32'(st_emit_len));
    end
    if (push) begin
      out_kind_r  <= hold_kind_r;
      out_start_r <= hold_start_r;
      out_len_r   <= hold_len_r;
      out_last_r  <= (seq_r == lmt_pkg::SQ_FINISH);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_kind   = out_kind_r;
  assign out_start_offset = out_start_r;
  assign out_token_length = out_len_r;
  assign out_last_of_run  = out_last_r;

endmodule

// ===== rtl/lmt_step.sv =====
module lmt_step #(
  parameter int LENGTH_WIDTH = 16
) (
  input  lmt_pkg::step_op_t        op_i,
  input  lmt_pkg::scan_state_t     scan_i,
  input  logic                     skip_i,
  input  logic [7:0]               char_i,
  input  logic [31:0]              pos_i,
  input  logic [31:0]              tok_start_i,
  input  logic [LENGTH_WIDTH-1:0]  acc_len_i,
  input  logic [LENGTH_WIDTH-1:0]  scan_len_i,
  output lmt_pkg::scan_state_t     scan_o,
  output logic                     skip_o,
  output logic [31:0]              tok_start_o,
  output logic [LENGTH_WIDTH-1:0]  acc_len_o,
  output logic [LENGTH_WIDTH-1:0]  scan_len_o,
  output lmt_pkg::step_ctl_t       ctl_o,
  output logic [31:0]              emit_start_o,
  output logic [LENGTH_WIDTH-1:0]  emit_len_o
);

  logic [LENGTH_WIDTH-1:0] len_inc;
  lmt_pkg::scan_state_t    id_nxt;
  logic                    c_digit;
  logic                    c_letter;

  assign len_inc  = (&scan_len_i) ? scan_len_i : scan_len_i + 1'b1;
  assign c_digit  = lmt_pkg::is_digit(char_i);
  assign c_letter = lmt_pkg::is_letter(char_i);

  always_comb begin
    id_nxt = lmt_pkg::S_ID;
    case (scan_i)
      lmt_pkg::S_I: begin
        if (char_i == lmt_pkg::CH_LO_F) id_nxt = lmt_pkg::S_IF;
        else if (char_i == lmt_pkg::CH_LO_N) id_nxt = lmt_pkg::S_IN;
      end
      lmt_pkg::S_IN: begin
        if (char_i == lmt_pkg::CH_LO_T) id_nxt = lmt_pkg::S_INT;
      end
      lmt_pkg::S_E: begin
        if (char_i == lmt_pkg::CH_LO_L) id_nxt = lmt_pkg::S_EL;
      end
      lmt_pkg::S_EL: begin
        if (char_i == lmt_pkg::CH_LO_S) id_nxt = lmt_pkg::S_ELS;
      end
      lmt_pkg::S_ELS: begin
        if (char_i == lmt_pkg::CH_LO_E) id_nxt = lmt_pkg::S_ELSE;
      end
      default: id_nxt = lmt_pkg::S_ID;
    endcase
  end

  always_comb begin
    scan_o       = scan_i;
    skip_o       = skip_i;
    tok_start_o  = tok_start_i;
    acc_len_o    = acc_len_i;
    scan_len_o   = scan_len_i;
    ctl_o        = '0;
    ctl_o.kind   = lmt_pkg::K_NUM;
    emit_start_o = tok_start_i;
    emit_len_o   = acc_len_i;
    if (op_i == lmt_pkg::OP_FLUSH) begin
      if (!skip_i && lmt_pkg::is_num_state(scan_i)) begin
        ctl_o.emit     = 1'b1;
        ctl_o.fail     = 1'b1;
        ctl_o.pend_cnt = lmt_pkg::pending_count(scan_i);
        scan_o         = lmt_pkg::S_IDLE;
      end else begin
        if (!skip_i && (scan_i != lmt_pkg::S_IDLE)) begin
          ctl_o.emit = 1'b1;
          ctl_o.kind = lmt_pkg::id_kind(scan_i);
        end
        scan_o = lmt_pkg::S_IDLE;
        skip_o = 1'b0;
      end
    end else if (!skip_i) begin
      if (scan_i == lmt_pkg::S_IDLE) begin
        if (c_digit || c_letter) begin
          tok_start_o = pos_i;
          scan_len_o  = LENGTH_WIDTH'(1);
          acc_len_o   = LENGTH_WIDTH'(1);
          if (c_digit) begin
            scan_o = lmt_pkg::S_NINT;
          end else if (char_i == lmt_pkg::CH_LO_I) begin
            scan_o = lmt_pkg::S_I;
          end else if (char_i == lmt_pkg::CH_LO_E) begin
            scan_o = lmt_pkg::S_E;
          end else begin
            scan_o = lmt_pkg::S_ID;
          end
        end else begin
          ctl_o.emit   = 1'b1;
          emit_start_o = pos_i;
          emit_len_o   = LENGTH_WIDTH'(1);
          case (char_i)
            lmt_pkg::CH_LPAREN:  ctl_o.kind = lmt_pkg::K_LPAREN;
            lmt_pkg::CH_RPAREN:  ctl_o.kind = lmt_pkg::K_RPAREN;
            lmt_pkg::CH_EQUAL:   ctl_o.kind = lmt_pkg::K_EQUAL;
            lmt_pkg::CH_LESS:    ctl_o.kind = lmt_pkg::K_LESS;
            lmt_pkg::CH_GREATER: ctl_o.kind = lmt_pkg::K_GREATER;
            default: begin
              ctl_o.kind = lmt_pkg::K_INVALID;
              emit_len_o = '0;
              skip_o     = 1'b1;
            end
          endcase
        end
      end else if ((op_i == lmt_pkg::OP_ADVANCE) && lmt_pkg::is_num_state(scan_i)) begin
        if (c_digit) begin
          case (scan_i)
            lmt_pkg::S_NINT:                  scan_o = lmt_pkg::S_NINT;
            lmt_pkg::S_NDOT, lmt_pkg::S_NFRAC: scan_o = lmt_pkg::S_NFRAC;
            default:                          scan_o = lmt_pkg::S_NEXP;
          endcase
          scan_len_o = len_inc;
          acc_len_o  = len_inc;
        end else if ((scan_i == lmt_pkg::S_NINT) && (char_i == lmt_pkg::CH_DOT)) begin
          scan_o       = lmt_pkg::S_NDOT;
          ctl_o.lb_wr0 = 1'b1;
          scan_len_o   = len_inc;
        end else if (((scan_i == lmt_pkg::S_NINT) || (scan_i == lmt_pkg::S_NFRAC)) &&
                     (char_i == lmt_pkg::CH_UP_E)) begin
          scan_o       = lmt_pkg::S_NE;
          ctl_o.lb_wr0 = 1'b1;
          scan_len_o   = len_inc;
        end else if ((scan_i == lmt_pkg::S_NE) &&
                     ((char_i == lmt_pkg::CH_PLUS) || (char_i == lmt_pkg::CH_MINUS))) begin
          scan_o       = lmt_pkg::S_NESIGN;
          ctl_o.lb_wr1 = 1'b1;
          scan_len_o   = len_inc;
        end else begin
          ctl_o.emit     = 1'b1;
          ctl_o.fail     = 1'b1;
          ctl_o.pend_cnt = lmt_pkg::pending_count(scan_i);
          scan_o         = lmt_pkg::S_IDLE;
        end
      end else if (lmt_pkg::is_id_state(scan_i) && (c_letter || c_digit)) begin
        scan_o     = id_nxt;
        scan_len_o = len_inc;
        acc_len_o  = len_inc;
      end else if (lmt_pkg::is_num_state(scan_i) && c_digit) begin
        scan_len_o = len_inc;
        acc_len_o  = len_inc;
      end else begin
        ctl_o.emit  = 1'b1;
        ctl_o.retry = 1'b1;
        ctl_o.kind  = lmt_pkg::is_id_state(scan_i) ? lmt_pkg::id_kind(scan_i) : lmt_pkg::K_NUM;
        scan_o      = lmt_pkg::S_IDLE;
      end
    end
  end

endmodule

// ===== rtl/lmt_checker.sv =====
`include "longest_match_tokenizer_defines.svh"

module lmt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_char_code,
  input logic        in_end_of_text,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_token_kind,
  input logic [31:0] out_start_offset,
  input logic [15:0] out_token_length,
  input logic        out_last_of_run
);

  logic        punct_kind;
  logic        invalid_kind;
  logic [8:0]  in_bundle;
  logic [52:0] out_bundle;

  assign punct_kind = (out_token_kind == lmt_pkg::K_LPAREN) ||
                      (out_token_kind == lmt_pkg::K_RPAREN) ||
                      (out_token_kind == lmt_pkg::K_EQUAL) ||
                      (out_token_kind == lmt_pkg::K_LESS) ||
                      (out_token_kind == lmt_pkg::K_GREATER);
  assign invalid_kind = (out_token_kind == lmt_pkg::K_INVALID);
  assign in_bundle    = {in_char_code, in_end_of_text};
  assign out_bundle   = {out_token_kind, out_start_offset, out_token_length, out_last_of_run};

  `LMT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bundle))
  `LMT_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_bundle))
  `LMT_ASSERT_SAME(a_kind_range, clk, rst_n, out_valid, out_token_kind <= lmt_pkg::K_INVALID)
  `LMT_ASSERT_SAME(a_invalid_len, clk, rst_n, out_valid && invalid_kind, out_token_length == 16'd0)
  `LMT_ASSERT_SAME(a_punct_len, clk, rst_n, out_valid && punct_kind, out_token_length == 16'd1)

endmodule

bind longest_match_tokenizer lmt_checker u_lmt_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LEN_SAT = 65535;
  localparam int LONG_DIGITS = 24;
  localparam int RANDOM_ITEMS = 220;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_TOKENS_PER_ITEM = 4;

  typedef struct {
    lmt_pkg::tok_kind_t kind;
    logic [31:0]        start;
    logic [15:0]        tok_len;
    logic               last_flag;
  } token_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_code = 8'h00;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_token_kind;
  logic [31:0] out_start_offset;
  logic [15:0] out_token_length;
  logic        out_last_of_run;

  lmt_pkg::scan_state_t lx_state;
  logic [31:0] lx_pos;
  logic [31:0] lx_start;
  int unsigned lx_acc;
  int unsigned lx_scan;
  logic [7:0]  lx_held [2];
  logic        lx_skip;

  token_t      step_toks[$];
  token_t      expected_tokens[$];
  logic [7:0]  lexeme_bytes[$];
  string       keywords[3] = '{"if", "else", "int"};
  string       prefixes[5] = '{"i", "e", "in", "el", "els"};

  int  err_count = 0;
  int  tokens_checked = 0;
  int  items_sent = 0;
  int  directed_items = 0;
  int  quiet_cycles = 0;
  int  rx_cycle = 0;
  int  rx_hold = 0;
  int  burst_left = 0;
  bit  pacing = 1'b0;

  longest_match_tokenizer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_start_offset (out_start_offset),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  always #5 clk = ~clk;

  function automatic bit byte_is_digit(logic [7:0] c);
    return c >= lmt_pkg::CH_0 && c <= lmt_pkg::CH_9;
  endfunction

  function automatic bit byte_is_letter(logic [7:0] c);
    return (c >= lmt_pkg::CH_LO_A && c <= lmt_pkg::CH_LO_Z) ||
           (c >= lmt_pkg::CH_UP_A && c <= lmt_pkg::CH_UP_Z);
  endfunction

  function automatic bit byte_is_blank(logic [7:0] c);
    return c == lmt_pkg::CH_SPACE || (c >= lmt_pkg::CH_TAB && c <= lmt_pkg::CH_CR);
  endfunction

  function automatic bit state_in_number(lmt_pkg::scan_state_t s);
    return s >= lmt_pkg::S_NINT && s <= lmt_pkg::S_NEXP;
  endfunction

  function automatic bit state_in_word(lmt_pkg::scan_state_t s);
    return s >= lmt_pkg::S_ID && s <= lmt_pkg::S_ELSE;
  endfunction

  function automatic lmt_pkg::tok_kind_t word_kind(lmt_pkg::scan_state_t s);
    case (s)
      lmt_pkg::S_IF:   return lmt_pkg::K_IF;
      lmt_pkg::S_ELSE: return lmt_pkg::K_ELSE;
      lmt_pkg::S_INT:  return lmt_pkg::K_INT;
      default:         return lmt_pkg::K_ID;
    endcase
  endfunction

  function automatic int held_count(lmt_pkg::scan_state_t s);
    if (s == lmt_pkg::S_NDOT || s == lmt_pkg::S_NE) return 1;
    if (s == lmt_pkg::S_NESIGN) return 2;
    return 0;
  endfunction

  function automatic void put_tok(lmt_pkg::tok_kind_t k, logic [31:0] off, int unsigned len);
    token_t t;
    if (step_toks.size() >= MAX_TOKENS_PER_ITEM) return;
    t.kind = k;
    t.start = off;
    t.tok_len = (len > LEN_SAT) ? 16'hFFFF : len[15:0];
    t.last_flag = 1'b0;
    step_toks.insert(step_toks.size(), t);
  endfunction

  function automatic void grow();
    if (lx_scan < LEN_SAT) lx_scan++;
  endfunction

  function automatic void open_token(logic [7:0] c, logic [31:0] p);
    lx_state = lmt_pkg::S_IDLE;
    if (byte_is_digit(c) || byte_is_letter(c)) begin
      lx_start = p;
      lx_scan = 1;
      lx_acc = 1;
      if (byte_is_digit(c)) lx_state = lmt_pkg::S_NINT;
      else if (c == lmt_pkg::CH_LO_I) lx_state = lmt_pkg::S_I;
      else if (c == lmt_pkg::CH_LO_E) lx_state = lmt_pkg::S_E;
      else lx_state = lmt_pkg::S_ID;
      return;
    end
    case (c)
      lmt_pkg::CH_LPAREN:  put_tok(lmt_pkg::K_LPAREN, p, 1);
      lmt_pkg::CH_RPAREN:  put_tok(lmt_pkg::K_RPAREN, p, 1);
      lmt_pkg::CH_EQUAL:   put_tok(lmt_pkg::K_EQUAL, p, 1);
      lmt_pkg::CH_LESS:    put_tok(lmt_pkg::K_LESS, p, 1);
      lmt_pkg::CH_GREATER: put_tok(lmt_pkg::K_GREATER, p, 1);
      default: begin
        put_tok(lmt_pkg::K_INVALID, p, 0);
        lx_skip = 1'b1;
      end
    endcase
  endfunction

  function automatic void plain_byte(logic [7:0] c, logic [31:0] p);
    lmt_pkg::scan_state_t nxt;
    if (lx_skip) return;
    if (lx_state == lmt_pkg::S_IDLE) begin
      open_token(c, p);
      return;
    end
    if (state_in_word(lx_state) && (byte_is_letter(c) || byte_is_digit(c))) begin
      nxt = lmt_pkg::S_ID;
      if (lx_state == lmt_pkg::S_I && c == lmt_pkg::CH_LO_F) nxt = lmt_pkg::S_IF;
      else if (lx_state == lmt_pkg::S_I && c == lmt_pkg::CH_LO_N) nxt = lmt_pkg::S_IN;
      else if (lx_state == lmt_pkg::S_IN && c == lmt_pkg::CH_LO_T) nxt = lmt_pkg::S_INT;
      else if (lx_state == lmt_pkg::S_E && c == lmt_pkg::CH_LO_L) nxt = lmt_pkg::S_EL;
      else if (lx_state == lmt_pkg::S_EL && c == lmt_pkg::CH_LO_S) nxt = lmt_pkg::S_ELS;
      else if (lx_state == lmt_pkg::S_ELS && c == lmt_pkg::CH_LO_E) nxt = lmt_pkg::S_ELSE;
      lx_state = nxt;
      grow();
      lx_acc = lx_scan;
      return;
    end
    if (state_in_number(lx_state) && byte_is_digit(c)) begin
      grow();
      lx_acc = lx_scan;
      return;
    end
    put_tok(state_in_word(lx_state) ? word_kind(lx_state) : lmt_pkg::K_NUM, lx_start, lx_acc);
    lx_state = lmt_pkg::S_IDLE;
    open_token(c, p);
  endfunction

  // The number is cut at its last accepting point and the held bytes go through again.
  function automatic void abandon_number(logic [31:0] p);
    int k;
    logic [7:0] b0, b1;
    k = held_count(lx_state);
    b0 = lx_held[0];
    b1 = lx_held[1];
    put_tok(lmt_pkg::K_NUM, lx_start, lx_acc);
    lx_state = lmt_pkg::S_IDLE;
    if (k >= 1) plain_byte(b0, p - k);
    if (k == 2) plain_byte(b1, p - 1);
  endfunction

  function automatic void feed_byte(logic [7:0] c, logic [31:0] p);
    lmt_pkg::scan_state_t nxt;
    bit accept;
    accept = 1'b0;
    if (lx_skip || !state_in_number(lx_state)) begin
      plain_byte(c, p);
      return;
    end
    if (byte_is_digit(c)) begin
      if (lx_state == lmt_pkg::S_NINT) nxt = lmt_pkg::S_NINT;
      else if (lx_state == lmt_pkg::S_NDOT || lx_state == lmt_pkg::S_NFRAC)
        nxt = lmt_pkg::S_NFRAC;
      else nxt = lmt_pkg::S_NEXP;
      accept = 1'b1;
    end else if (lx_state == lmt_pkg::S_NINT && c == lmt_pkg::CH_DOT) begin
      nxt = lmt_pkg::S_NDOT;
      lx_held[0] = c;
    end else if ((lx_state == lmt_pkg::S_NINT || lx_state == lmt_pkg::S_NFRAC) &&
                 c == lmt_pkg::CH_UP_E) begin
      nxt = lmt_pkg::S_NE;
      lx_held[0] = c;
    end else if (lx_state == lmt_pkg::S_NE &&
                 (c == lmt_pkg::CH_PLUS || c == lmt_pkg::CH_MINUS)) begin
      nxt = lmt_pkg::S_NESIGN;
      lx_held[1] = c;
    end else begin
      abandon_number(p);
      plain_byte(c, p);
      return;
    end
    lx_state = nxt;
    grow();
    if (accept) lx_acc = lx_scan;
  endfunction

  function automatic void close_word();
    if (!lx_skip && state_in_number(lx_state)) abandon_number(lx_pos);
    if (!lx_skip && lx_state != lmt_pkg::S_IDLE)
      put_tok(state_in_word(lx_state) ? word_kind(lx_state) : lmt_pkg::K_NUM,
              lx_start, lx_acc);
    lx_state = lmt_pkg::S_IDLE;
    lx_skip = 1'b0;
  endfunction

  function automatic void predict_tokens(logic [7:0] c, logic eot);
    step_toks.delete();
    if (eot) begin
      close_word();
    end else begin
      if (byte_is_blank(c)) close_word();
      else feed_byte(c, lx_pos);
      lx_pos++;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_flag = 1'b1;
    foreach (step_toks[i]) expected_tokens.insert(expected_tokens.size(), step_toks[i]);
  endfunction

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic send_item(input logic [7:0] c, input logic eot);
    int gap;
    in_valid <= 1'b1;
    in_char_code <= c;
    in_end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tokens(c, eot);
    items_sent++;
    if (pacing) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_queued();
    while (lexeme_bytes.size() != 0) send_item(lexeme_bytes.pop_front(), 1'b0);
  endtask

  task automatic drain();
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic void add_byte(logic [7:0] b);
    lexeme_bytes.insert(lexeme_bytes.size(), b);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(lmt_pkg::CH_0 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'(lmt_pkg::CH_0 + r);
    if (r < 36) return 8'(lmt_pkg::CH_LO_A + (r - 10));
    return 8'(lmt_pkg::CH_UP_A + (r - 36));
  endfunction

  function automatic logic [7:0] rand_blank();
    if ($urandom_range(0, 5) == 5) return lmt_pkg::CH_SPACE;
    return 8'(lmt_pkg::CH_TAB + $urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 4))
      0:       return lmt_pkg::CH_LPAREN;
      1:       return lmt_pkg::CH_RPAREN;
      2:       return lmt_pkg::CH_EQUAL;
      3:       return lmt_pkg::CH_LESS;
      default: return lmt_pkg::CH_GREATER;
    endcase
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // Numbers are sometimes cut short after the dot, the E or the sign.
  function automatic void add_number();
    int r;
    repeat ($urandom_range(1, 4)) add_byte(rand_digit());
    if ($urandom_range(0, 1) == 1) begin
      add_byte(lmt_pkg::CH_DOT);
      if ($urandom_range(0, 5) != 0) repeat ($urandom_range(1, 3)) add_byte(rand_digit());
    end
    if ($urandom_range(0, 9) < 4) begin
      add_byte(lmt_pkg::CH_UP_E);
      r = $urandom_range(0, 2);
      if (r == 1) add_byte(lmt_pkg::CH_PLUS);
      if (r == 2) add_byte(lmt_pkg::CH_MINUS);
      if ($urandom_range(0, 5) != 0) repeat ($urandom_range(1, 3)) add_byte(rand_digit());
    end
  endfunction

  function automatic void add_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      push_text(keywords[$urandom_range(0, 2)]);
    end else if (r < 6) begin
      push_text(prefixes[$urandom_range(0, 4)]);
      repeat ($urandom_range(0, 2)) add_byte(rand_alnum());
    end else begin
      add_byte(($urandom_range(0, 1) == 1) ? 8'(lmt_pkg::CH_LO_A + $urandom_range(0, 25))
                                           : 8'(lmt_pkg::CH_UP_A + $urandom_range(0, 25)));
      repeat ($urandom_range(0, 5)) add_byte(rand_alnum());
    end
  endfunction

  function automatic void add_lexeme();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) add_number();
    else if (r < 78) add_word();
    else if (r < 90) add_byte(rand_operator());
    else add_byte(8'($urandom_range(0, 255)));
  endfunction

  task automatic test_operators_keywords();
    send_text("if(else)=int<a9>");
    send_item(8'h0B, 1'b0);
    stop_input();
  endtask

  task automatic test_number_forms();
    send_text("1.5E-3");
    send_item(lmt_pkg::CH_CR, 1'b0);
    send_text("2E+");
    send_item(8'($urandom_range(0, 255)), 1'b1);
    send_text("7.");
    send_item(8'hFF, 1'b0);
    send_item(8'h0C, 1'b0);
    stop_input();
  endtask

  task automatic test_invalid_bytes();
    send_item(8'h00, 1'b0);
    send_item(lmt_pkg::CH_LO_Z, 1'b0);
    send_item(8'h80, 1'b1);
    stop_input();
    drain();
  endtask

  task automatic test_result_backpressure();
    rx_hold = 400;
    repeat (14) begin
      add_lexeme();
      add_lexeme();
      send_queued();
      send_item(rand_blank(), 1'b0);
    end
    stop_input();
    drain();
  endtask

  task automatic test_long_number();
    repeat (LONG_DIGITS) send_item(rand_digit(), 1'b0);
    send_text("E+");
    send_item(lmt_pkg::CH_SPACE, 1'b0);
    stop_input();
    drain();
  endtask

  task automatic test_random_stream();
    int sent_here;
    int r;
    bit paused;
    sent_here = 0;
    paused = 1'b0;
    pacing = 1'b1;
    while (sent_here < RANDOM_ITEMS) begin
      add_lexeme();
      sent_here += lexeme_bytes.size();
      send_queued();
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_item(rand_blank(), 1'b0);
        sent_here++;
      end else if (r < 67) begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
        sent_here++;
      end
      if (!paused && sent_here >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        stop_input();
        drain();
      end
    end
    pacing = 1'b0;
    stop_input();
  endtask

  always @(posedge clk) begin : rx_side
    token_t want;
    if (rst_n && out_valid && out_ready) begin
      tokens_checked++;
      if (expected_tokens.size() == 0) begin
        report($sformatf("unexpected token kind %0d at offset %0d",
                         out_token_kind, out_start_offset));
      end else begin
        want = expected_tokens.pop_front();
        if (out_token_kind !== want.kind)
          report($sformatf("token %0d kind: expected %0d, got %0d",
                           tokens_checked, want.kind, out_token_kind));
        if (out_start_offset !== want.start)
          report($sformatf("token %0d offset: expected %0d, got %0d",
                           tokens_checked, want.start, out_start_offset));
        if (out_token_length !== want.tok_len)
          report($sformatf("token %0d length: expected %0d, got %0d",
                           tokens_checked, want.tok_len, out_token_length));
        if (out_last_of_run !== want.last_flag)
          report($sformatf("token %0d last flag: expected %0b, got %0b",
                           tokens_checked, want.last_flag, out_last_of_run));
      end
    end
    rx_cycle++;
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 50) % 4)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 99) < 75);
        2:       out_ready <= ($urandom_range(0, 99) < 30);
        default: out_ready <= rx_cycle[0];
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    lx_state = lmt_pkg::S_IDLE;
    lx_pos = '0;
    lx_start = '0;
    lx_acc = 0;
    lx_scan = 0;
    lx_held[0] = '0;
    lx_held[1] = '0;
    lx_skip = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_operators_keywords();
    test_number_forms();
    test_invalid_bytes();
    directed_items = items_sent;
    test_result_backpressure();
    test_long_number();
    test_random_stream();
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d input items (%0d directed, one number of %0d digits) and checked %0d tokens.",
             items_sent, directed_items, LONG_DIGITS, tokens_checked);
    $display("Mismatches: %0d", err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lmt_pkg.sv
rtl/lmt_step.sv
rtl/longest_match_tokenizer.sv
rtl/lmt_checker.sv
test/tb.sv
